### hdl/hbe_pkg.sv
// hbe_pkg: shared types and constants of the histogram binning engine
// action and register codes, controller/datapath command and status structs
// no dependencies
`default_nettype none

package hbe_pkg;

	localparam int HBE_MAX_BINS = 256;

	localparam int SAMPLE_W = 32;
	localparam int COUNT_W  = 32;
	localparam int INDEX_W  = 8;
	localparam int BINS_W   = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [SAMPLE_W-1:0] RANGE_MIN_RST = '0;
	localparam logic [31:0]         BIN_SCALE_RST = 32'h0001_0000;
	localparam logic [BINS_W-1:0]   BINS_RST      = 9'd256;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_READ   = 2'd2,
		ACT_MINMAX = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIN_MODE    = 2'd0,
		CFG_RANGE_MIN   = 2'd1,
		CFG_BIN_SCALE   = 2'd2,
		CFG_BINS_IN_USE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic load;
		logic diff;
		logic mul;
		logic locate;
		logic read_bin;
		logic clr_wr;
		logic cnt_clr;
		logic scan_rd;
		logic res;
	} dp_cmd_t;

	typedef struct packed {
		logic last_all;
		logic last_use;
		logic slot_free;
	} dp_sts_t;

endpackage

`default_nettype wire

### hdl/hbe_req_if.sv
// hbe_req_if: request channel of the histogram engine (valid/ready + payload)
// depends on hbe_pkg
`default_nettype none

interface hbe_req_if;
	logic                          valid;
	logic                          ready;
	hbe_pkg::action_t              action;
	logic [hbe_pkg::SAMPLE_W-1:0]  sample;
	logic                          sample_invalid;
	logic [hbe_pkg::INDEX_W-1:0]   bin_index;

	modport source (output valid, action, sample, sample_invalid, bin_index, input ready);
	modport sink   (input valid, action, sample, sample_invalid, bin_index, output ready);
endinterface

`default_nettype wire

### hdl/hbe_rsp_if.sv
// hbe_rsp_if: result channel of the histogram engine (valid/ready + payload)
// depends on hbe_pkg
`default_nettype none

interface hbe_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [hbe_pkg::COUNT_W-1:0]  bin_value;
	logic [hbe_pkg::COUNT_W-1:0]  min_count;
	logic [hbe_pkg::COUNT_W-1:0]  max_count;
	logic                         dropped;

	modport source (output valid, bin_value, min_count, max_count, dropped, input ready);
	modport sink   (input valid, bin_value, min_count, max_count, dropped, output ready);
endinterface

`default_nettype wire

### hdl/hbe_cfg_if.sv
// hbe_cfg_if: register write channel of the histogram engine
// depends on hbe_pkg
`default_nettype none

interface hbe_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hbe_pkg::CFG_IDX_W-1:0]  index;
	logic [31:0]                    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/hbe_ram.sv
// hbe_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module hbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

`default_nettype wire

### hdl/hbe_dp.sv
// hbe_dp: datapath of the histogram engine: config registers, bin locate
// (subtract, multiply, range check), bin memory, min/max scan, result register
// depends on hbe_pkg and hbe_ram
`default_nettype none

module hbe_dp #(
	parameter int MAX_BINS = hbe_pkg::HBE_MAX_BINS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire hbe_pkg::dp_cmd_t                cmd,
	output      hbe_pkg::dp_sts_t                sts,
	input  wire logic                            cfg_we,
	input  wire logic [hbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                     cfg_data,
	input  wire hbe_pkg::action_t                action,
	input  wire logic [hbe_pkg::SAMPLE_W-1:0]    sample,
	input  wire logic                            sample_invalid,
	input  wire logic [hbe_pkg::INDEX_W-1:0]     bin_index,
	input  wire logic                            rsp_ready,
	output      logic                            rsp_valid,
	output      logic [hbe_pkg::COUNT_W-1:0]     bin_value,
	output      logic [hbe_pkg::COUNT_W-1:0]     min_count,
	output      logic [hbe_pkg::COUNT_W-1:0]     max_count,
	output      logic                            dropped
);
	import hbe_pkg::*;

	localparam int AW = $clog2(MAX_BINS);
	localparam int NW = (AW + 1 > BINS_W) ? AW + 1 : BINS_W;
	localparam logic [NW-1:0] NMAX = NW'(MAX_BINS);
	localparam logic [AW-1:0] LAST_ALL = AW'(MAX_BINS - 1);

	// configuration
	logic                mode_q;
	logic [SAMPLE_W-1:0] range_min_q;
	logic [31:0]         bin_scale_q;
	logic [BINS_W-1:0]   bins_q;

	// request capture and locate pipeline
	action_t              act_s1;
	logic [SAMPLE_W-1:0]  sample_s1;
	logic                 invalid_s1;
	logic [INDEX_W-1:0]   index_s1;
	logic [SAMPLE_W:0]    diff_s2;
	logic [63:0]          prod_s3;

	logic [AW-1:0]        bin_q;
	logic                 miss_q;
	logic [AW-1:0]        cnt_q;
	logic                 sv_q;
	logic                 first_q;
	logic [COUNT_W-1:0]   mn_q;
	logic [COUNT_W-1:0]   mx_q;
	logic                 rsp_valid_q;

	logic [NW-1:0]        bins_w;
	logic [NW-1:0]        nlast_w;
	logic [AW-1:0]        nlast;
	logic [31:0]          loc_idx;
	logic                 loc_ok;
	logic                 loc_hit;
	logic [31:0]          rd_idx32;
	logic                 rd_in;
	logic [COUNT_W-1:0]   inc;

	logic                 ram_wr_en;
	logic [AW-1:0]        ram_wr_addr;
	logic [COUNT_W-1:0]   ram_wr_data;
	logic                 ram_rd_en;
	logic [AW-1:0]        ram_rd_addr;
	logic [COUNT_W-1:0]   ram_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			range_min_q <= RANGE_MIN_RST;
			bin_scale_q <= BIN_SCALE_RST;
			bins_q      <= BINS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_BIN_MODE:    mode_q      <= cfg_data[0];
				CFG_RANGE_MIN:   range_min_q <= cfg_data;
				CFG_BIN_SCALE:   bin_scale_q <= cfg_data;
				CFG_BINS_IN_USE: bins_q      <= cfg_data[BINS_W-1:0];
				default:         mode_q      <= mode_q;
			endcase
		end
	end

	// last bin in use: zero acts as one bin, above capacity acts as capacity
	always_comb begin
		bins_w = NW'(bins_q);
		priority if (bins_w == '0) begin
			nlast_w = '0;
		end else if (bins_w > NMAX) begin
			nlast_w = NMAX - NW'(1);
		end else begin
			nlast_w = bins_w - NW'(1);
		end
		nlast = nlast_w[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_s1     <= action;
			sample_s1  <= sample;
			invalid_s1 <= sample_invalid;
			index_s1   <= bin_index;
		end
		if (cmd.diff) begin
			diff_s2 <= {sample_s1[SAMPLE_W-1], sample_s1}
				- {range_min_q[SAMPLE_W-1], range_min_q};
		end
		if (cmd.mul) begin
			prod_s3 <= 64'(diff_s2[SAMPLE_W-1:0]) * 64'(bin_scale_q);
		end
	end

	// bin number from the offset; scaled mode takes the integer part of Q32.32
	always_comb begin
		loc_idx = '0;
		loc_ok  = 1'b0;
		if (mode_q) begin
			if (diff_s2[SAMPLE_W]) begin
				loc_ok = (bin_scale_q == '0);
			end else begin
				loc_idx = prod_s3[63:32];
				loc_ok  = 1'b1;
			end
		end else begin
			loc_idx = {16'd0, diff_s2[31:16]};
			loc_ok  = !diff_s2[SAMPLE_W];
		end
		loc_hit  = loc_ok && !invalid_s1 && (loc_idx <= 32'(nlast));
		rd_idx32 = 32'(index_s1);
		rd_in    = (rd_idx32 <= 32'(nlast));
	end

	assign inc = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + COUNT_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.locate) begin
			bin_q  <= loc_idx[AW-1:0];
			miss_q <= !loc_hit;
		end else if (cmd.read_bin) begin
			miss_q <= !rd_in;
		end
	end

	always_comb begin
		priority if (cmd.locate) begin
			ram_rd_addr = loc_idx[AW-1:0];
		end else if (cmd.read_bin) begin
			ram_rd_addr = rd_idx32[AW-1:0];
		end else begin
			ram_rd_addr = cnt_q;
		end
		ram_rd_en   = (cmd.locate && loc_hit) || (cmd.read_bin && rd_in) || cmd.scan_rd;
		ram_wr_en   = cmd.clr_wr || (cmd.res && (act_s1 == ACT_ADD) && !miss_q);
		ram_wr_addr = cmd.clr_wr ? cnt_q : bin_q;
		ram_wr_data = cmd.clr_wr ? '0 : inc;
	end

	hbe_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(MAX_BINS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// sweep counter for clear and min/max walk; scan data lands in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sv_q    <= 1'b0;
			first_q <= 1'b1;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.clr_wr || cmd.scan_rd) begin
				cnt_q <= cnt_q + AW'(1);
			end
			sv_q <= cmd.scan_rd;
			if (cmd.cnt_clr) begin
				first_q <= 1'b1;
			end else if (sv_q) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (first_q || (ram_rd_data < mn_q)) begin
				mn_q <= ram_rd_data;
			end
			if (first_q || (ram_rd_data > mx_q)) begin
				mx_q <= ram_rd_data;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res) begin
			bin_value <= '0;
			min_count <= '0;
			max_count <= '0;
			dropped   <= 1'b0;
			unique case (act_s1)
				ACT_CLEAR: begin
				end
				ACT_ADD: begin
					bin_value <= miss_q ? '0 : inc;
					dropped   <= miss_q;
				end
				ACT_READ: begin
					bin_value <= miss_q ? '0 : ram_rd_data;
				end
				ACT_MINMAX: begin
					min_count <= mn_q;
					max_count <= mx_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign sts.last_all  = (cnt_q == LAST_ALL);
	assign sts.last_use  = (cnt_q == nlast);
	assign sts.slot_free = !rsp_valid_q || rsp_ready;
endmodule

`default_nettype wire

### hdl/hbe_ctrl.sv
// hbe_ctrl: sequencer of the histogram engine, one request at a time
// depends on hbe_pkg; drives the datapath by dp_cmd_t and reads dp_sts_t
`default_nettype none

module hbe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire hbe_pkg::action_t  req_action,
	output      logic              req_ready,
	input  wire hbe_pkg::dp_sts_t  sts,
	output      hbe_pkg::dp_cmd_t  cmd
);
	import hbe_pkg::*;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DIFF,
		S_MUL,
		S_LOC,
		S_RDB,
		S_CLR,
		S_SCAN,
		S_DRAIN,
		S_RES
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_wr = 1'b1;
				if (sts.last_all) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid && ready_q) begin
					cmd.load    = 1'b1;
					cmd.cnt_clr = 1'b1;
					unique case (req_action)
						ACT_CLEAR:  state_d = S_CLR;
						ACT_ADD:    state_d = S_DIFF;
						ACT_READ:   state_d = S_RDB;
						ACT_MINMAX: state_d = S_SCAN;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_LOC;
			end
			S_LOC: begin
				cmd.locate = 1'b1;
				state_d    = S_RES;
			end
			S_RDB: begin
				cmd.read_bin = 1'b1;
				state_d      = S_RES;
			end
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.last_all) begin
					state_d = S_RES;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.last_use) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_RES;
			end
			S_RES: begin
				// hold until the result register is free
				if (sts.slot_free) begin
					cmd.res = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
		end
	end

	assign req_ready = ready_q;
endmodule

`default_nettype wire

### hdl/histogram_binning_engine_top.sv
// Histogram binning engine over a memory of MAX_BINS saturating 32-bit counters.
// Channels: req (action, sample, sample_invalid, bin_index), rsp (bin_value,
// min_count, max_count, dropped), cfg (register index, data); all valid/ready.
// Every request gives exactly one response, in order; one request is worked
// at a time, and the next may be taken while a response waits in rsp.
// Steps from accept to response, per action:
//   add:     subtract, multiply, range check with bin read, increment and
//            write back
//   read:    bin read with index range check
//   clear:   one bin memory write per cycle, over all MAX_BINS bins
//   min/max: one bin memory read per cycle, over the bins in use
// Reset clears the registers to their defaults and then zeroes all MAX_BINS
// bins of the bin memory; req.ready stays low during that pass, cfg is taken.
// If rsp is stalled the finished response is held and the engine stops
// before its next response; cfg writes are taken at any time but must only
// be made while no request is outstanding.
// depends on hbe_pkg, the channel interfaces, hbe_ctrl, hbe_dp
`default_nettype none

module histogram_binning_engine_top #(
	parameter int MAX_BINS = hbe_pkg::HBE_MAX_BINS
) (
	input wire logic   clk,
	input wire logic   arst_n,
	hbe_req_if.sink    req,
	hbe_rsp_if.source  rsp,
	hbe_cfg_if.sink    cfg
);
	import hbe_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	hbe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	hbe_dp #(
		.MAX_BINS(MAX_BINS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.action         (req.action),
		.sample         (req.sample),
		.sample_invalid (req.sample_invalid),
		.bin_index      (req.bin_index),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.bin_value      (rsp.bin_value),
		.min_count      (rsp.min_count),
		.max_count      (rsp.max_count),
		.dropped        (rsp.dropped)
	);
endmodule

`default_nettype wire

### hdl/hbe_chk.sv
// hbe_chk: port-level checks of the histogram engine, bound to the top level
// depends on histogram_binning_engine_top
`default_nettype none

module hbe_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] bin_value,
	input wire logic [31:0] min_count,
	input wire logic [31:0] max_count,
	input wire logic        dropped
);
	// a stalled response stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// a stalled response keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(bin_value) && $stable(min_count)
			&& $stable(max_count) && $stable(dropped))
		else $error("response payload changed while stalled");

	// one request in flight: no back-to-back accepts
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// a dropped sample carries no counts
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && dropped |-> bin_value == '0 && min_count == '0 && max_count == '0)
		else $error("dropped response with nonzero counts");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> min_count <= max_count)
		else $error("min count above max count");
endmodule

bind histogram_binning_engine_top hbe_chk u_hbe_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.bin_value (rsp.bin_value),
	.min_count (rsp.min_count),
	.max_count (rsp.max_count),
	.dropped   (rsp.dropped)
);

`default_nettype wire

### tb/hbe_bin_tracker.sv
`timescale 1ns / 100ps
// hbe_bin_tracker: keeps its own copy of the engine's registers and bin counters,
// works out each response from the requests it sees and compares them in order
// depends on hbe_pkg and the hbe_req_if, hbe_rsp_if and hbe_cfg_if channels
module hbe_bin_tracker (
	input  logic clk,
	input  logic arst_n,
	hbe_req_if   req,
	hbe_rsp_if   rsp,
	hbe_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	import hbe_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0] bin_value;
		logic [COUNT_W-1:0] min_count;
		logic [COUNT_W-1:0] max_count;
		logic               dropped;
	} bin_result_t;

	logic [COUNT_W-1:0]  counts [HBE_MAX_BINS];
	logic                scaled_mode;
	logic [SAMPLE_W-1:0] lower_edge;
	logic [31:0]         scale;
	logic [BINS_W-1:0]   bins_reg;
	bin_result_t         awaiting [$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic int live_bins();
		if (bins_reg == '0)
			return 1;
		if (bins_reg > HBE_MAX_BINS)
			return HBE_MAX_BINS;
		return int'(bins_reg);
	endfunction

	function automatic logic locate_bin(input logic [SAMPLE_W-1:0] value, output int bin);
		longint      offset;
		logic [63:0] product;
		logic [63:0] index64;
		bin = 0;
		index64 = '0;
		offset = $signed(value);
		offset -= $signed(lower_edge);
		if (offset < 0) begin
			// below the lower edge only scaled mode with a zero scale still lands in bin 0
			if (!scaled_mode || scale != '0)
				return 1'b0;
		end else if (scaled_mode) begin
			product = 64'(offset) * 64'(scale);
			index64 = product >> 32;
		end else begin
			index64 = 64'(offset) >> 16;
		end
		if (index64 >= 64'(live_bins()))
			return 1'b0;
		bin = int'(index64);
		return 1'b1;
	endfunction

	function automatic bin_result_t next_result(input action_t act,
			input logic [SAMPLE_W-1:0] value, input logic bad,
			input logic [INDEX_W-1:0] idx);
		bin_result_t r;
		int          bin;
		int          n;
		int          i;
		r = '0;
		n = live_bins();
		case (act)
		ACT_CLEAR: begin
			for (i = 0; i < HBE_MAX_BINS; i++)
				counts[i] = '0;
		end
		ACT_ADD: begin
			if (!bad && locate_bin(value, bin)) begin
				if (counts[bin] != '1)
					counts[bin] = counts[bin] + 1'b1;
				r.bin_value = counts[bin];
			end else begin
				r.dropped = 1'b1;
			end
		end
		ACT_READ: begin
			if (int'(idx) < n)
				r.bin_value = counts[idx];
		end
		ACT_MINMAX: begin
			r.min_count = counts[0];
			r.max_count = counts[0];
			for (i = 1; i < n; i++) begin
				if (counts[i] < r.min_count)
					r.min_count = counts[i];
				if (counts[i] > r.max_count)
					r.max_count = counts[i];
			end
		end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		$display("%0t bin tracker: %s got %h want %h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		bin_result_t want;
		int          i;
		if (!arst_n) begin
			for (i = 0; i < HBE_MAX_BINS; i++)
				counts[i] = '0;
			scaled_mode = 1'b0;
			lower_edge = RANGE_MIN_RST;
			scale = BIN_SCALE_RST;
			bins_reg = BINS_RST;
			awaiting.delete();
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
				CFG_BIN_MODE:    scaled_mode = cfg.data[0];
				CFG_RANGE_MIN:   lower_edge = cfg.data;
				CFG_BIN_SCALE:   scale = cfg.data;
				CFG_BINS_IN_USE: bins_reg = cfg.data[BINS_W-1:0];
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (awaiting.size() == 0) begin
					report_mismatch("response with no request outstanding, bin_value",
						rsp.bin_value, '0);
				end else begin
					want = awaiting.pop_front();
					if (rsp.bin_value !== want.bin_value)
						report_mismatch("bin_value", rsp.bin_value, want.bin_value);
					if (rsp.min_count !== want.min_count)
						report_mismatch("min_count", rsp.min_count, want.min_count);
					if (rsp.max_count !== want.max_count)
						report_mismatch("max_count", rsp.max_count, want.max_count);
					if (rsp.dropped !== want.dropped)
						report_mismatch("dropped", 32'(rsp.dropped), 32'(want.dropped));
				end
			end
			if (req.valid && req.ready)
				awaiting.push_back(next_result(req.action, req.sample,
					req.sample_invalid, req.bin_index));
			pending = awaiting.size();
		end
	end

endmodule

### tb/tb_histogram_binning_engine_top.sv
`timescale 1ns / 100ps
// tb_histogram_binning_engine_top: directed and random requests with random idling
// on both channels, register settings changed between phases; hbe_bin_tracker checks
// depends on hbe_pkg, the channel interfaces, histogram_binning_engine_top, hbe_bin_tracker
module tb_histogram_binning_engine_top;
	import hbe_pkg::*;

	localparam int RUN_LIMIT    = 1_500_000;
	localparam int PHASES       = 8;
	localparam int PER_PHASE    = 116;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	bit   steady;

	// register values last written, used to aim samples at bins
	logic              cur_mode;
	logic [31:0]       cur_lower;
	logic [31:0]       cur_scale;
	logic [BINS_W-1:0] cur_bins;

	hbe_req_if req_ch ();
	hbe_rsp_if rsp_ch ();
	hbe_cfg_if cfg_ch ();

	histogram_binning_engine_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	hbe_bin_tracker bin_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("histogram_binning_engine_top verification failed");
			$finish;
		end
	end

	function automatic int idle_span();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		int hold;
		hold = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0)
				hold--;
			else
				hold = idle_span();
			rsp_ch.ready <= (hold == 0);
		end
	end

	function automatic int active_count();
		if (cur_bins == '0)
			return 1;
		if (cur_bins > HBE_MAX_BINS)
			return HBE_MAX_BINS;
		return int'(cur_bins);
	endfunction

	// a sample whose bin should be target under the current settings
	function automatic logic [31:0] aimed_sample(input int target);
		logic [63:0] offset;
		offset = 64'(target);
		if (!cur_mode)
			offset = (offset << 16) | 64'($urandom_range(0, 16'hFFFF));
		else if (cur_scale == '0)
			offset = 64'($urandom);
		else
			offset = ((offset << 32) + 64'($urandom)) / 64'(cur_scale);
		return cur_lower + offset[31:0];
	endfunction

	// valid is left high after acceptance so back-to-back requests need one assignment
	task automatic send_request(input action_t act, input logic [31:0] value,
			input logic bad, input logic [7:0] idx);
		int gap;
		gap = idle_span();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.sample <= value;
		req_ch.sample_invalid <= bad;
		req_ch.bin_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain_requests();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_register(input cfg_reg_t which, input logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= which;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic set_config(input logic mode, input logic [31:0] lower,
			input logic [31:0] scale, input logic [BINS_W-1:0] bin_total);
		write_register(CFG_BIN_MODE, {31'b0, mode});
		write_register(CFG_RANGE_MIN, lower);
		write_register(CFG_BIN_SCALE, scale);
		write_register(CFG_BINS_IN_USE, {23'b0, bin_total});
		cfg_ch.valid <= 1'b0;
		cur_mode = mode;
		cur_lower = lower;
		cur_scale = scale;
		cur_bins = bin_total;
	endtask

	task automatic run_directed();
		// reset settings: direct binning from 0, all 256 bins
		send_request(ACT_READ, $urandom, 1'b0, 8'd0);
		send_request(ACT_MINMAX, $urandom, 1'b1, 8'($urandom));
		send_request(ACT_ADD, 32'h0000_0000, 1'b0, 8'($urandom));
		send_request(ACT_ADD, 32'h00FF_FFFF, 1'b0, 8'($urandom));
		send_request(ACT_ADD, 32'h0100_0000, 1'b0, 8'($urandom));
		send_request(ACT_ADD, 32'h8000_0000, 1'b0, 8'($urandom));
		send_request(ACT_ADD, 32'h7FFF_FFFF, 1'b0, 8'($urandom));
		send_request(ACT_ADD, 32'h0000_8000, 1'b1, 8'($urandom));
		send_request(ACT_READ, $urandom, 1'b0, 8'd255);
		send_request(ACT_MINMAX, $urandom, 1'b0, 8'($urandom));
		drain_requests();
		// bin 255 leaves use but keeps its count
		set_config(1'b0, 32'h0, 32'h0001_0000, 9'd4);
		send_request(ACT_READ, $urandom, 1'b0, 8'd255);
		send_request(ACT_MINMAX, $urandom, 1'b0, 8'($urandom));
		drain_requests();
		// zero bins in use behaves as one
		set_config(1'b0, 32'h0, 32'h0001_0000, 9'd0);
		send_request(ACT_ADD, 32'h0001_0000, 1'b0, 8'($urandom));
		send_request(ACT_MINMAX, $urandom, 1'b0, 8'($urandom));
		drain_requests();
		// zero scale: even samples below the edge fall in bin 0
		set_config(1'b1, 32'h7FFF_FFFF, 32'h0, 9'd511);
		send_request(ACT_ADD, 32'h8000_0000, 1'b0, 8'($urandom));
		send_request(ACT_ADD, 32'h7FFF_FFFF, 1'b0, 8'($urandom));
		drain_requests();
		set_config(1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 9'd256);
		send_request(ACT_ADD, 32'h8000_0000, 1'b0, 8'($urandom));
		send_request(ACT_ADD, 32'h8000_0100, 1'b0, 8'($urandom));
		send_request(ACT_ADD, 32'h8000_0101, 1'b0, 8'($urandom));
		send_request(ACT_ADD, 32'h7FFF_FFFF, 1'b0, 8'($urandom));
		send_request(ACT_READ, $urandom, 1'b0, 8'd255);
		send_request(ACT_CLEAR, $urandom, 1'b1, 8'($urandom));
		send_request(ACT_MINMAX, $urandom, 1'b0, 8'($urandom));
		send_request(ACT_READ, $urandom, 1'b0, 8'd0);
		drain_requests();
	endtask

	task automatic choose_setting(input int phase_no);
		logic              mode;
		logic [31:0]       lower;
		logic [31:0]       scale;
		logic [BINS_W-1:0] bin_total;
		mode = 1'($urandom_range(0, 1));
		lower = $urandom;
		scale = $urandom >> $urandom_range(0, 24);
		if ($urandom_range(0, 4) == 0)
			bin_total = 9'($urandom_range(257, 511));
		else if ($urandom_range(0, 3) == 0)
			bin_total = 9'($urandom_range(1, 256));
		else
			bin_total = 9'($urandom_range(1, 32));
		case (phase_no)
		0: set_config(1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 9'd256);
		1: set_config(1'b1, 32'h7FFF_FFFF, 32'h0, 9'd511);
		2: set_config(1'b1, lower, 32'hFFFF_FFFF, 9'd2);
		3: set_config(1'b0, lower, scale, 9'd0);
		default: set_config(mode, lower, scale, bin_total);
		endcase
	endtask

	task automatic random_request();
		int          roll;
		int          n;
		action_t     act;
		logic [31:0] value;
		logic        bad;
		logic [7:0]  idx;
		roll = $urandom_range(0, 99);
		n = active_count();
		value = $urandom;
		bad = 1'($urandom_range(0, 1));
		idx = 8'($urandom);
		if (roll < 2) begin
			act = ACT_CLEAR;
		end else if (roll < 6) begin
			act = ACT_MINMAX;
		end else if (roll < 16) begin
			act = ACT_READ;
			if ($urandom_range(0, 3) != 0)
				idx = 8'($urandom_range(0, n - 1));
		end else begin
			act = ACT_ADD;
			if ($urandom_range(0, 99) < 85) begin
				// mostly inside the range, now and then one bin past the end
				value = aimed_sample($urandom_range(0, 19) == 0 ? n : $urandom_range(0, n - 1));
				bad = 1'b0;
			end else begin
				if ($urandom_range(0, 1) == 0)
					value = aimed_sample($urandom_range(0, n - 1));
				bad = ($urandom_range(0, 3) == 0);
			end
		end
		send_request(act, value, bad, idx);
	endtask

	initial begin
		int phase_no;
		int k;
		arst_n = 1'b0;
		steady = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_CLEAR;
		req_ch.sample = '0;
		req_ch.sample_invalid = 1'b0;
		req_ch.bin_index = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_BIN_MODE;
		cfg_ch.data = '0;
		cur_mode = 1'b0;
		cur_lower = RANGE_MIN_RST;
		cur_scale = BIN_SCALE_RST;
		cur_bins = BINS_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (phase_no = 0; phase_no < PHASES; phase_no++) begin
			choose_setting(phase_no);
			steady = (phase_no % 3 == 1);
			for (k = 0; k < PER_PHASE; k++)
				random_request();
			drain_requests();
		end
		steady = 1'b0;
		repeat (HBE_MAX_BINS + 8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("histogram_binning_engine_top verification clean");
		else
			$display("histogram_binning_engine_top verification failed");
		$finish;
	end

endmodule

### sim.f
hdl/hbe_pkg.sv
hdl/hbe_req_if.sv
hdl/hbe_rsp_if.sv
hdl/hbe_cfg_if.sv
hdl/hbe_ram.sv
hdl/hbe_dp.sv
hdl/hbe_ctrl.sv
hdl/histogram_binning_engine_top.sv
hdl/hbe_chk.sv
tb/hbe_bin_tracker.sv
tb/tb_histogram_binning_engine_top.sv
